### sv/vsm_pkg.sv
package vsm_pkg;
    localparam int MaxLength = 1024;
    localparam int AccWidth = 48;
    localparam int CntWidth = $clog2(MaxLength + 1);
    localparam int RootWidth = AccWidth / 2;
    localparam int DenWidth = 2 * RootWidth;

    typedef enum logic [1:0] {
        ACT_DOT  = 2'd0,
        ACT_DIST = 2'd1,
        ACT_COS  = 2'd2,
        ACT_NORM = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]                 action;
        logic signed [AccWidth-1:0] sp;
        logic signed [AccWidth-1:0] sa;
        logic signed [AccWidth-1:0] sb;
        logic signed [AccWidth-1:0] sd;
    } t_job;
endpackage

### sv/vsm_front.sv
module vsm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic [1:0]     i_action,
    input  logic signed [15:0] i_a_elem,
    input  logic signed [15:0] i_b_elem,
    input  logic           i_last,
    output logic           o_job_valid,
    output vsm_pkg::t_job  o_job,
    input  logic           i_job_ready
);
    import vsm_pkg::*;

    localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
    localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

    // stage 1 registers the products, stage 2 accumulates
    logic                       r_v1, r_last1, r_acc1;
    logic [1:0]                 r_act1;
    logic signed [33:0]         r_pab, r_paa, r_pbb, r_pdd;
    logic signed [AccWidth-1:0] r_sp, r_sa, r_sb, r_sd;
    logic signed [AccWidth-1:0] n_sp, n_sa, n_sb, n_sd;
    logic [CntWidth-1:0]        r_cnt;
    logic                       r_jv;
    t_job                       r_job;
    logic signed [16:0]         w_d;
    logic                       w_take;

    function automatic logic signed [AccWidth-1:0] sat_add(
        input logic signed [AccWidth-1:0] acc, input logic signed [33:0] x);
        logic signed [AccWidth:0] s;
        begin
            s = (AccWidth+1)'(acc) + (AccWidth+1)'(x);
            if (s[AccWidth] != s[AccWidth-1]) begin
                sat_add = s[AccWidth] ? AccMin : AccMax;
            end else begin
                sat_add = s[AccWidth-1:0];
            end
        end
    endfunction

    // stall the input while a finished vector is still held and another last pair waits in stage 1
    assign o_full = r_jv && r_v1 && r_last1;
    assign w_take = i_push && !o_full;
    assign w_d = {i_a_elem[15], i_a_elem} - {i_b_elem[15], i_b_elem};

    always_comb begin
        n_sp = r_sp;
        n_sa = r_sa;
        n_sb = r_sb;
        n_sd = r_sd;
        if (r_v1 && r_acc1) begin
            n_sp = sat_add(r_sp, r_pab);
            n_sa = sat_add(r_sa, r_paa);
            n_sb = sat_add(r_sb, r_pbb);
            n_sd = sat_add(r_sd, r_pdd);
        end
    end

    assign o_job_valid = r_jv;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_jv <= 1'b0;
            r_cnt <= '0;
            r_sp <= '0;
            r_sa <= '0;
            r_sb <= '0;
            r_sd <= '0;
        end else begin
            if (r_jv && i_job_ready) begin
                r_jv <= 1'b0;
            end
            if (!o_full) begin
                r_v1 <= w_take;
                if (w_take) begin
                    r_last1 <= i_last;
                    r_act1 <= i_action;
                    r_acc1 <= (r_cnt < CntWidth'(MaxLength));
                    r_pab <= 34'(i_a_elem * i_b_elem);
                    r_paa <= 34'(i_a_elem * i_a_elem);
                    r_pbb <= 34'(i_b_elem * i_b_elem);
                    r_pdd <= 34'(w_d * w_d);
                    if (i_last) begin
                        r_cnt <= '0;
                    end else if (r_cnt < CntWidth'(MaxLength)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                if (r_v1 && r_last1) begin
                    r_jv <= 1'b1;
                    r_job <= '{action: r_act1, sp: n_sp, sa: n_sa, sb: n_sb, sd: n_sd};
                    r_sp <= '0;
                    r_sa <= '0;
                    r_sb <= '0;
                    r_sd <= '0;
                end else begin
                    r_sp <= n_sp;
                    r_sa <= n_sa;
                    r_sb <= n_sb;
                    r_sd <= n_sd;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_full_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> r_jv) else $error("full without held job");
    a_job_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jv && !i_job_ready |=> r_jv && $stable(r_job)) else $error("job lost");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_last1 && !o_full |=> r_sp == '0 && r_sd == '0)
        else $error("sums not cleared");
`endif
endmodule

### sv/vsm_back.sv
module vsm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  vsm_pkg::t_job        i_job,
    output logic                 o_job_ready,
    output logic                 o_res_valid,
    output logic signed [47:0]   o_result,
    output logic [1:0]           o_metric,
    output logic                 o_zero_norm,
    input  logic                 i_res_ready
);
    import vsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SQA, S_SQB, S_MUL, S_DIV, S_DONE
    } t_state;

    t_state                     r_state;
    t_job                       r_job;
    logic [AccWidth-1:0]        r_rem;
    logic [RootWidth-1:0]       r_root;
    logic [5:0]                 r_step;
    logic [RootWidth-1:0]       r_na;
    logic [DenWidth-1:0]        r_den;
    logic [DenWidth:0]          r_drem;
    logic [15:0]                r_q;
    logic                       r_neg;
    logic                       r_ov;
    logic signed [47:0]         r_result;
    logic [1:0]                 r_metric;
    logic                       r_zn;
    logic                       r_rv;

    logic [AccWidth-1:0]        w_mag;
    logic [RootWidth+1:0]       w_trial;
    logic [DenWidth+1:0]        w_d2;

    assign w_mag = r_job.sp[AccWidth-1] ? AccWidth'(-r_job.sp) : AccWidth'(r_job.sp);
    // one result bit per step, restoring square root
    assign w_trial = {r_root, 2'b01};
    assign w_d2 = {r_drem, 1'b0};

    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = r_rv;
    assign o_result = r_result;
    assign o_metric = r_metric;
    assign o_zero_norm = r_zn;

    logic [RootWidth+1:0] r_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv <= 1'b0;
        end else begin
            if (r_rv && i_res_ready) begin
                r_rv <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_state <= S_SQA;
                        r_rem <= (i_job.action == ACT_DIST) ? AccWidth'(i_job.sd)
                                                            : AccWidth'(i_job.sa);
                        r_part <= '0;
                        r_root <= '0;
                        r_step <= '0;
                    end
                end
                S_SQA, S_SQB: begin
                    if (w_trial <= {r_part[RootWidth-1:0], r_rem[AccWidth-1:AccWidth-2]}) begin
                        r_part <= {r_part[RootWidth-1:0], r_rem[AccWidth-1:AccWidth-2]} - w_trial;
                        r_root <= {r_root[RootWidth-2:0], 1'b1};
                    end else begin
                        r_part <= {r_part[RootWidth-1:0], r_rem[AccWidth-1:AccWidth-2]};
                        r_root <= {r_root[RootWidth-2:0], 1'b0};
                    end
                    r_rem <= {r_rem[AccWidth-3:0], 2'b00};
                    r_step <= r_step + 1'b1;
                    if (r_step == 6'(RootWidth - 1)) begin
                        r_step <= '0;
                        if (r_state == S_SQA && r_job.action == ACT_COS) begin
                            r_na <= (w_trial <= {r_part[RootWidth-1:0],
                                      r_rem[AccWidth-1:AccWidth-2]})
                                    ? {r_root[RootWidth-2:0], 1'b1}
                                    : {r_root[RootWidth-2:0], 1'b0};
                            r_rem <= AccWidth'(r_job.sb);
                            r_part <= '0;
                            r_root <= '0;
                            r_state <= S_SQB;
                        end else if (r_state == S_SQB) begin
                            r_state <= S_MUL;
                            r_root <= (w_trial <= {r_part[RootWidth-1:0],
                                       r_rem[AccWidth-1:AccWidth-2]})
                                      ? {r_root[RootWidth-2:0], 1'b1}
                                      : {r_root[RootWidth-2:0], 1'b0};
                        end else begin
                            r_state <= S_DONE;
                            r_root <= (w_trial <= {r_part[RootWidth-1:0],
                                       r_rem[AccWidth-1:AccWidth-2]})
                                      ? {r_root[RootWidth-2:0], 1'b1}
                                      : {r_root[RootWidth-2:0], 1'b0};
                        end
                    end
                end
                S_MUL: begin
                    r_den <= r_na * r_root;
                    r_neg <= r_job.sp[AccWidth-1];
                    r_step <= '0;
                    r_q <= '0;
                    r_state <= S_DIV;
                    r_ov <= 1'b0;
                end
                S_DIV: begin
                    // step 0 checks for a zero divisor and for num >= den (overflow), then 15 fraction bits
                    r_step <= r_step + 1'b1;
                    if (r_step == '0) begin
                        if (r_den == '0) begin
                            r_state <= S_DONE;
                        end else if (w_mag >= r_den) begin
                            r_ov <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_drem <= {1'b0, w_mag};
                        end
                    end else begin
                        if (w_d2 >= {2'b00, r_den}) begin
                            r_drem <= (DenWidth+1)'(w_d2 - {2'b00, r_den});
                            r_q <= {r_q[14:0], 1'b1};
                        end else begin
                            r_drem <= (DenWidth+1)'(w_d2);
                            r_q <= {r_q[14:0], 1'b0};
                        end
                        if (r_step == 6'd15) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_rv) begin
                        r_rv <= 1'b1;
                        r_metric <= r_job.action;
                        r_zn <= 1'b0;
                        case (t_action'(r_job.action))
                            ACT_DOT: r_result <= 48'(r_job.sp);
                            ACT_DIST, ACT_NORM: r_result <= 48'(r_root);
                            ACT_COS: begin
                                if (r_den == '0) begin
                                    r_result <= '0;
                                    r_zn <= 1'b1;
                                end else if (r_ov) begin
                                    r_result <= r_neg ? -48'sd32768 : 48'sd32767;
                                end else begin
                                    r_result <= r_neg ? -48'($signed({1'b0, r_q}))
                                                      : 48'($signed({1'b0, r_q}));
                                end
                            end
                            default: r_result <= '0;
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_res_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv && !i_res_ready |=> r_rv && $stable(r_result)) else $error("result lost");
    a_zn_cos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv && r_zn |-> r_metric == ACT_COS) else $error("zero_norm off cosine");
    a_zn_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv && r_zn |-> r_result == '0) else $error("zero_norm with value");
`endif
endmodule

### sv/vector_similarity_metrics.sv
// vector similarity metrics
// input channel: push/full carry one element pair (action, a_elem, b_elem,
// last); a transfer happens when push is high and full low
// result channel: empty/pop; the result is on the ports while empty is low
// and leaves on a transfer with pop high
// pairs are taken one per cycle while full is low; products are registered,
// then summed into four saturating 48-bit accumulators
// the pair with last set hands the sums to the back end, which runs the
// square roots (one bit a cycle) and the cosine divide (the product of the
// two roots, then a zero and overflow check and 15 quotient bits)
// the back end takes no new vector until it has registered the current
// result; the next vector accumulates meanwhile
// a second finished vector waits in the handoff register; a third last pair
// stalls the input until the back end takes a job
// reset clears the sums, the element count and every valid flag
// a stalled result stays on the ports unchanged until popped
module vector_similarity_metrics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_a_elem,
    input  logic signed [15:0] i_b_elem,
    input  logic               i_last,
    output logic               empty,
    input  logic               pop,
    output logic signed [47:0] o_result,
    output logic [1:0]         o_metric,
    output logic               o_zero_norm
);
    import vsm_pkg::*;

    logic  w_jv, w_jr, w_rv;
    t_job  w_job;

    vsm_front u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .o_full(full),
        .i_action, .i_a_elem, .i_b_elem, .i_last,
        .o_job_valid(w_jv), .o_job(w_job), .i_job_ready(w_jr)
    );

    vsm_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_jv), .i_job(w_job), .o_job_ready(w_jr),
        .o_res_valid(w_rv), .o_result, .o_metric, .o_zero_norm,
        .i_res_ready(pop)
    );

    assign empty = !w_rv;
endmodule

### bench/vector_similarity_metrics_tb.sv
module vector_similarity_metrics_tb;
    import vsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint AccMax = (longint'(1) <<< (AccWidth - 1)) - 1;
    localparam longint AccMin = -AccMax - 1;
    localparam int IdleLimit = 20000;

    typedef struct {
        logic signed [47:0] result;
        logic [1:0]         metric;
        logic               zero_norm;
    } t_metric_out;

    typedef struct {
        t_action            action;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
        logic               typed;
        logic signed [47:0] result;
        logic               zero_norm;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [1:0]         i_action;
    logic signed [15:0] i_a_elem;
    logic signed [15:0] i_b_elem;
    logic               i_last;
    logic               empty;
    logic               pop;
    logic signed [47:0] o_result;
    logic [1:0]         o_metric;
    logic               o_zero_norm;

    t_metric_out pending_metrics[$];
    longint      dot_sum, a_sq_sum, b_sq_sum, diff_sq_sum;
    int          pair_count;
    int          error_count;
    int          idle_cycles;
    int          send_gap_pct;
    int          pop_stall_pct;

    vector_similarity_metrics DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_action   (i_action),
        .i_a_elem   (i_a_elem),
        .i_b_elem   (i_b_elem),
        .i_last     (i_last),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .o_metric   (o_metric),
        .o_zero_norm(o_zero_norm)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint sat_sum(longint acc, longint x);
        if (x > 0 && acc > AccMax - x) return AccMax;
        if (x < 0 && acc < AccMin - x) return AccMin;
        return acc + x;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned cos_fraction(longint unsigned num, longint unsigned den);
        longint unsigned rem;
        longint unsigned q;
        q = 0;
        if (num / den >= 1) return 32768;
        rem = num % den;
        for (int i = 0; i < 15; i++) begin
            q <<= 1;
            if (rem >= den - rem) begin
                rem = rem - (den - rem);
                q |= 1;
            end else begin
                rem = rem + rem;
            end
        end
        return q;
    endfunction

    // accumulate one pair; returns 1 with the metric when the vector ends
    function automatic bit accumulate_pair(t_action act, logic signed [15:0] a,
                                           logic signed [15:0] b, logic last,
                                           output t_metric_out m);
        longint av, bv, dv, value;
        longint unsigned na, nb, den, mag, q;
        m.zero_norm = 1'b0;
        m.metric = act;
        value = 0;
        if (pair_count < MaxLength) begin
            av = a;
            bv = b;
            dv = av - bv;
            dot_sum = sat_sum(dot_sum, av * bv);
            a_sq_sum = sat_sum(a_sq_sum, av * av);
            b_sq_sum = sat_sum(b_sq_sum, bv * bv);
            diff_sq_sum = sat_sum(diff_sq_sum, dv * dv);
            pair_count++;
        end
        if (!last) return 0;
        case (act)
            ACT_DOT:  value = dot_sum;
            ACT_DIST: value = longint'(floor_root(diff_sq_sum));
            ACT_NORM: value = longint'(floor_root(a_sq_sum));
            default: begin
                na = floor_root(a_sq_sum);
                nb = floor_root(b_sq_sum);
                den = na * nb;
                if (den == 0) begin
                    m.zero_norm = 1'b1;
                end else if (dot_sum < 0) begin
                    mag = -dot_sum;
                    value = -longint'(cos_fraction(mag, den));
                end else begin
                    q = cos_fraction(dot_sum, den);
                    value = (q > 32767) ? 32767 : longint'(q);
                end
            end
        endcase
        m.result = value[47:0];
        dot_sum = 0;
        a_sq_sum = 0;
        b_sq_sum = 0;
        diff_sq_sum = 0;
        pair_count = 0;
        return 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_pair(t_action act, logic signed [15:0] a, logic signed [15:0] b,
                             logic last, logic typed = 1'b0,
                             logic signed [47:0] typed_result = '0,
                             logic typed_zero = 1'b0);
        t_metric_out m;
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_action <= act;
        i_a_elem <= a;
        i_b_elem <= b;
        i_last <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (accumulate_pair(act, a, b, last, m)) begin
            if (typed) begin
                m.result = typed_result;
                m.zero_norm = typed_zero;
            end
            pending_metrics.push_back(m);
        end
    endtask

    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_metrics.size() == 0) begin
                    report_mismatch("unexpected result", o_result, 0);
                end else begin
                    t_metric_out w;
                    w = pending_metrics.pop_front();
                    if (o_result !== w.result) report_mismatch("result", o_result, w.result);
                    if (o_metric !== w.metric) report_mismatch("metric", o_metric, w.metric);
                    if (o_zero_norm !== w.zero_norm)
                        report_mismatch("zero_norm", o_zero_norm, w.zero_norm);
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end else begin
            pop <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    t_row rows[$] = '{
        '{ACT_DOT,  16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 48'sd1073676289, 1'b0},
        '{ACT_DOT,  16'sh8000, 16'sh8000, 1'b1, 1'b1, 48'sd1073741824, 1'b0},
        '{ACT_DOT,  16'sh8000, 16'sh7fff, 1'b1, 1'b1, -48'sd1073709056, 1'b0},
        '{ACT_NORM, 16'sh8000, 16'sh0000, 1'b1, 1'b1, 48'sd32768, 1'b0},
        '{ACT_DIST, 16'sh7fff, 16'sh8000, 1'b1, 1'b1, 48'sd65535, 1'b0},
        '{ACT_DIST, 16'sh1234, 16'sh1234, 1'b1, 1'b1, 48'sd0, 1'b0},
        '{ACT_COS,  16'sh0000, 16'sh0005, 1'b1, 1'b1, 48'sd0, 1'b1},
        '{ACT_COS,  16'sh0005, 16'sh0000, 1'b1, 1'b1, 48'sd0, 1'b1},
        '{ACT_COS,  16'sh1000, 16'sh1000, 1'b1, 1'b1, 48'sd32767, 1'b0},
        '{ACT_COS,  16'sh1000, -16'sh1000, 1'b1, 1'b1, -48'sd32768, 1'b0},
        '{ACT_DOT,  16'sh0123, 16'sh0f00, 1'b0, 1'b0, '0, 1'b0},
        '{ACT_NORM, -16'sh2000, 16'sh7000, 1'b0, 1'b0, '0, 1'b0},
        '{ACT_COS,  16'sh3000, 16'sh1000, 1'b1, 1'b0, '0, 1'b0},
        '{ACT_COS,  16'sh1000, 16'sh3000, 1'b0, 1'b0, '0, 1'b0},
        '{ACT_COS,  16'sh3000, -16'sh1000, 1'b1, 1'b0, '0, 1'b0},
        '{ACT_DIST, 16'sh4000, -16'sh4000, 1'b0, 1'b0, '0, 1'b0},
        '{ACT_DIST, 16'sh0001, 16'sh0002, 1'b1, 1'b0, '0, 1'b0},
        '{ACT_NORM, 16'sh7fff, 16'sh0000, 1'b0, 1'b0, '0, 1'b0},
        '{ACT_NORM, 16'sh7fff, 16'sh0000, 1'b1, 1'b0, '0, 1'b0}
    };

    initial begin
        int len;
        int phase_items;
        t_action act;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_action = '0;
        i_a_elem = '0;
        i_b_elem = '0;
        i_last = 1'b0;
        error_count = 0;
        send_gap_pct = 0;
        pop_stall_pct = 0;
        dot_sum = 0;
        a_sq_sum = 0;
        b_sq_sum = 0;
        diff_sq_sum = 0;
        pair_count = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_pair(rows[i].action, rows[i].a, rows[i].b, rows[i].last,
                      rows[i].typed, rows[i].result, rows[i].zero_norm);

        // vector longer than the element limit
        for (int i = 0; i < MaxLength + 8; i++)
            send_pair(ACT_DOT, pick_elem(), pick_elem(), i == MaxLength + 7);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_gap_pct = 49; pop_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  pop_stall_pct = 49; end
                default: begin send_gap_pct = 23; pop_stall_pct = 23; end
            endcase
            phase_items = 0;
            while (phase_items < 150) begin
                act = t_action'($urandom_range(3));
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                for (int k = 0; k < len; k++)
                    send_pair(act, pick_elem(), pick_elem(),
                              k == len - 1 ? 1'b1 : 1'b0);
                phase_items += len;
            end
        end
        push <= 1'b0;
        send_gap_pct = 0;
        pop_stall_pct = 0;
        while (pending_metrics.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
